@@ design/tun_pkg.sv @@
// ----------------------------------------------------------------------------
// tun_pkg : shared types and constants of the triangle unit normal block
// default widths and the side data that travels along the cell rows
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // the largest scaled component magnitude keeps its leading one at bit 30
    localparam int MAG_BITS  = 31;
    localparam int SUM_BITS  = 64;
    localparam int ROOT_BITS = 32;
    localparam int SQ_CELLS  = 32;
    localparam int OUT_BITS  = 16;

    // side data through the square root row
    typedef struct packed {
        logic [2:0]          neg;
        logic [MAG_BITS-1:0] m0;
        logic [MAG_BITS-1:0] m1;
        logic [MAG_BITS-1:0] m2;
        logic                degen;
        logic                last;
    } t_sq_side;

    // side data through the divider row
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
        logic       last;
    } t_dv_side;

endpackage

@@ design/triangle_unit_normal_core.sv @@
// ----------------------------------------------------------------------------
// triangle_unit_normal_core : unit face normal of one triangle per cycle
// edge vectors, exact cross product, normalisation by the euclidean length
// ----------------------------------------------------------------------------
// usage
//   a request (three vertices plus the last mark) is taken at every rising
//   edge with start high; busy stays low, so a request may follow in every
//   cycle and many triangles are in flight at once
//   each result appears on the o_ ports for one cycle with o_valid high and
//   must be taken then; results leave in request order
//   one result per cycle sustained; a request passes through eight front
//   stages, a row of 32 square root cells (one root bit each), one numerator
//   stage, a row of NORMAL_FRAC_BITS + 2 divider cells (one quotient bit
//   each) and the output register
//   reset empties the pipeline; triangles in flight are dropped
//   a triangle with a zero cross product gives a zero normal and the
//   degenerate flag
// ----------------------------------------------------------------------------
module triangle_unit_normal_core #(
    parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_az,
    input  logic signed [15:0] i_bx,
    input  logic signed [15:0] i_by_coord,
    input  logic signed [15:0] i_bz,
    input  logic signed [15:0] i_cx,
    input  logic signed [15:0] i_cy,
    input  logic signed [15:0] i_cz,
    input  logic               i_last_in,
    output logic               o_valid,
    output logic signed [15:0] o_nx,
    output logic signed [15:0] o_ny,
    output logic signed [15:0] o_nz,
    output logic               o_degenerate,
    output logic               o_last_out
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int PW  = 2 * CW + 2;          // product width
    localparam int NW  = 2 * CW + 3;          // cross component width
    localparam int MW  = 2 * CW + 2;          // magnitude width
    localparam int LW  = $clog2(MW + 1);      // bit length width
    localparam int MB  = tun_pkg::MAG_BITS;
    localparam int QW  = F + 2;               // quotient width
    localparam int DW  = F + 34;              // divider remainder width
    localparam int NSQ = tun_pkg::SQ_CELLS;
    localparam int LAT = 10 + NSQ + QW;

    // no back pressure: every cycle can take a request
    assign busy = 1'b0;

    // ---------------------------------------------------------------- stage 0
    // coordinates: low COORD_WIDTH bits of each field, sign taken at the top
    logic [CW+15:0]        ext [9];
    logic signed [CW-1:0]  r_crd [9];
    logic [7:0]            r_vld;
    logic                  r_last [8];

    assign ext[0] = {{CW{1'b0}}, i_ax};
    assign ext[1] = {{CW{1'b0}}, i_ay};
    assign ext[2] = {{CW{1'b0}}, i_az};
    assign ext[3] = {{CW{1'b0}}, i_bx};
    assign ext[4] = {{CW{1'b0}}, i_by_coord};
    assign ext[5] = {{CW{1'b0}}, i_bz};
    assign ext[6] = {{CW{1'b0}}, i_cx};
    assign ext[7] = {{CW{1'b0}}, i_cy};
    assign ext[8] = {{CW{1'b0}}, i_cz};

    // front valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_crd[k] <= $signed(ext[k][CW-1:0]);
        end
        r_last[0] <= i_last_in;
        for (int k = 1; k < 8; k++) begin
            r_last[k] <= r_last[k-1];
        end
    end

    // ---------------------------------------------------------------- stage 1
    // edge vectors e1 = b - a, e2 = c - a
    logic signed [CW:0] r_e1 [3];
    logic signed [CW:0] r_e2 [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_e1[k] <= (CW+1)'(r_crd[3+k]) - (CW+1)'(r_crd[k]);
            r_e2[k] <= (CW+1)'(r_crd[6+k]) - (CW+1)'(r_crd[k]);
        end
    end

    // ---------------------------------------------------------------- stage 2
    // six products of the cross product
    logic signed [PW-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        r_p[0] <= PW'(r_e1[1]) * PW'(r_e2[2]);
        r_p[1] <= PW'(r_e1[2]) * PW'(r_e2[1]);
        r_p[2] <= PW'(r_e1[2]) * PW'(r_e2[0]);
        r_p[3] <= PW'(r_e1[0]) * PW'(r_e2[2]);
        r_p[4] <= PW'(r_e1[0]) * PW'(r_e2[1]);
        r_p[5] <= PW'(r_e1[1]) * PW'(r_e2[0]);
    end

    // ---------------------------------------------------------------- stage 3
    logic signed [NW-1:0] r_n [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_n[k] <= NW'(r_p[2*k]) - NW'(r_p[2*k+1]);
        end
    end

    // ---------------------------------------------------------------- stage 4
    // sign and magnitude, bit length of the largest magnitude
    logic [MW-1:0] n_mag [3];
    logic [MW-1:0] r_mag [3];
    logic [MW-1:0] mag_or;
    logic [LW-1:0] n_len, r_len;
    logic [2:0]    r_neg4;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = r_n[k][NW-1] ? MW'(-r_n[k]) : MW'(r_n[k]);
        end
        mag_or = n_mag[0] | n_mag[1] | n_mag[2];
        n_len  = '0;
        for (int k = 0; k < MW; k++) begin
            if (mag_or[k]) n_len = LW'(k + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_len <= n_len;
        for (int k = 0; k < 3; k++) begin
            r_neg4[k] <= r_n[k][NW-1];
        end
    end

    // ---------------------------------------------------------------- stage 5
    // common shift puts the largest leading one at bit 30
    logic [MW+MB-1:0] shl [3];
    logic [MB-1:0]    r_m [3];
    logic [2:0]       r_neg5, r_neg6, r_neg7;
    logic             r_dg5, r_dg6, r_dg7;
    logic [MB-1:0]    r_m6 [3];
    logic [MB-1:0]    r_m7 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            shl[k] = {r_mag[k], {MB{1'b0}}} >> r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_m[k] <= shl[k][MB-1:0];
        end
        r_neg5 <= r_neg4;
        r_dg5  <= (r_len == '0);
    end

    // ---------------------------------------------------------------- stage 6
    logic [2*MB-1:0] r_sq [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sq[k] <= (2*MB)'(r_m[k]) * (2*MB)'(r_m[k]);
        end
        r_m6   <= r_m;
        r_neg6 <= r_neg5;
        r_dg6  <= r_dg5;
    end

    // ---------------------------------------------------------------- stage 7
    logic [tun_pkg::SUM_BITS-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        r_sum  <= tun_pkg::SUM_BITS'(r_sq[0]) + tun_pkg::SUM_BITS'(r_sq[1])
                + tun_pkg::SUM_BITS'(r_sq[2]);
        r_m7   <= r_m6;
        r_neg7 <= r_neg6;
        r_dg7  <= r_dg6;
    end

    // ------------------------------------------------------ square root row
    logic                         sq_v    [NSQ+1];
    logic [tun_pkg::SUM_BITS-1:0] sq_x    [NSQ+1];
    logic [tun_pkg::SUM_BITS-1:0] sq_r    [NSQ+1];
    tun_pkg::t_sq_side            sq_side [NSQ+1];

    assign sq_v[0]          = r_vld[7];
    assign sq_x[0]          = r_sum;
    assign sq_r[0]          = '0;
    assign sq_side[0].neg   = r_neg7;
    assign sq_side[0].m0    = r_m7[0];
    assign sq_side[0].m1    = r_m7[1];
    assign sq_side[0].m2    = r_m7[2];
    assign sq_side[0].degen = r_dg7;
    assign sq_side[0].last  = r_last[7];

    for (genvar g = 0; g < NSQ; g++) begin : g_sq
        tun_sqrt_cell #(
            .BIT_POS (62 - 2 * g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[g]),
            .i_x     (sq_x[g]),
            .i_r     (sq_r[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_v[g+1]),
            .o_x     (sq_x[g+1]),
            .o_r     (sq_r[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // ------------------------------------------------------- numerator stage
    // numerator m << F plus half the length, for rounding half up
    logic [tun_pkg::ROOT_BITS-1:0] root;
    logic                          r_pv;
    logic [DW-1:0]                 r_num [3];
    logic [tun_pkg::ROOT_BITS-1:0] r_den;
    tun_pkg::t_dv_side             r_pside;

    assign root = sq_r[NSQ][tun_pkg::ROOT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= sq_v[NSQ];
        end
    end

    always_ff @(posedge i_clk) begin
        r_num[0] <= (DW'(sq_side[NSQ].m0) << F) + DW'(root >> 1);
        r_num[1] <= (DW'(sq_side[NSQ].m1) << F) + DW'(root >> 1);
        r_num[2] <= (DW'(sq_side[NSQ].m2) << F) + DW'(root >> 1);
        r_den          <= root;
        r_pside.neg    <= sq_side[NSQ].neg;
        r_pside.degen  <= sq_side[NSQ].degen;
        r_pside.last   <= sq_side[NSQ].last;
    end

    // ---------------------------------------------------------- divider row
    // cell g decides quotient bit QW-1-g
    logic                          dv_v    [QW+1];
    logic [DW-1:0]                 dv_rem  [QW+1][3];
    logic [QW-1:0]                 dv_q    [QW+1][3];
    logic [tun_pkg::ROOT_BITS-1:0] dv_den  [QW+1];
    tun_pkg::t_dv_side             dv_side [QW+1];

    assign dv_v[0]    = r_pv;
    assign dv_rem[0]  = r_num;
    assign dv_q[0]    = '{default: '0};
    assign dv_den[0]  = r_den;
    assign dv_side[0] = r_pside;

    for (genvar g = 0; g < QW; g++) begin : g_dv
        tun_div_cell #(
            .DW    (DW),
            .QW    (QW),
            .BIT_J (QW - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[g]),
            .i_rem   (dv_rem[g]),
            .i_q     (dv_q[g]),
            .i_den   (dv_den[g]),
            .i_side  (dv_side[g]),
            .o_valid (dv_v[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_q     (dv_q[g+1]),
            .o_den   (dv_den[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    // ---------------------------------------------------------- output stage
    // limit to one, apply the sign, zero a degenerate triangle, keep the low 16 bits
    localparam logic [QW-1:0] ONE = QW'(1) << F;

    logic [QW-1:0]                 qc  [3];
    logic [QW+tun_pkg::OUT_BITS-1:0] qe [3];
    logic [tun_pkg::OUT_BITS-1:0]  n_out [3];
    logic                          r_ov, r_odg, r_olast;
    logic [tun_pkg::OUT_BITS-1:0]  r_out [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qc[k] = (dv_q[QW][k] > ONE) ? ONE : dv_q[QW][k];
            qe[k] = {{tun_pkg::OUT_BITS{1'b0}}, qc[k]};
            if (dv_side[QW].neg[k]) begin
                qe[k] = ~qe[k] + 1'b1;
            end
            n_out[k] = dv_side[QW].degen ? '0 : qe[k][tun_pkg::OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_odg   <= dv_side[QW].degen;
        r_olast <= dv_side[QW].last;
    end

    assign o_valid      = r_ov;
    assign o_nx         = $signed(r_out[0]);
    assign o_ny         = $signed(r_out[1]);
    assign o_nz         = $signed(r_out[2]);
    assign o_degenerate = r_odg;
    assign o_last_out   = r_olast;

    // ------------------------------------------------------------ assertions
    // a result only comes from a request taken a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching request");

    // a degenerate triangle gives a zero normal
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_nx == 0 && o_ny == 0 && o_nz == 0))
        else $error("degenerate triangle with non-zero normal");

    // at the default fraction width components stay within plus or minus one
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && F == 14) |->
            (o_nx <= 16384 && o_nx >= -16384 && o_ny <= 16384 && o_ny >= -16384
             && o_nz <= 16384 && o_nz >= -16384))
        else $error("normal component out of range");

endmodule

@@ design/tun_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tun_sqrt_cell : one root bit of the integer square root row
// compares the running remainder with root plus the cell's weight
// ----------------------------------------------------------------------------
module tun_sqrt_cell #(
    parameter int BIT_POS = 62
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [tun_pkg::SUM_BITS-1:0]        i_x,
    input  logic [tun_pkg::SUM_BITS-1:0]        i_r,
    input  tun_pkg::t_sq_side                   i_side,
    output logic                                o_valid,
    output logic [tun_pkg::SUM_BITS-1:0]        o_x,
    output logic [tun_pkg::SUM_BITS-1:0]        o_r,
    output tun_pkg::t_sq_side                   o_side
);

    localparam logic [tun_pkg::SUM_BITS-1:0] WEIGHT =
        tun_pkg::SUM_BITS'(1) << BIT_POS;

    logic                          r_valid;
    logic [tun_pkg::SUM_BITS-1:0]  r_x, r_r, n_x, n_r, trial;
    tun_pkg::t_sq_side             r_side;

    always_comb begin
        trial = i_r + WEIGHT;
        if (i_x >= trial) begin
            n_x = i_x - trial;
            n_r = (i_r >> 1) + WEIGHT;
        end else begin
            n_x = i_x;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_r    <= n_r;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_r     = r_r;
    assign o_side  = r_side;

endmodule

@@ design/tun_div_cell.sv @@
// ----------------------------------------------------------------------------
// tun_div_cell : one quotient bit of the three-lane restoring divider row
// all three lanes share the same divisor, the square root length
// ----------------------------------------------------------------------------
module tun_div_cell #(
    parameter int DW    = 48,
    parameter int QW    = 16,
    parameter int BIT_J = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [DW-1:0]                     i_rem [3],
    input  logic [QW-1:0]                     i_q   [3],
    input  logic [tun_pkg::ROOT_BITS-1:0]     i_den,
    input  tun_pkg::t_dv_side                 i_side,
    output logic                              o_valid,
    output logic [DW-1:0]                     o_rem [3],
    output logic [QW-1:0]                     o_q   [3],
    output logic [tun_pkg::ROOT_BITS-1:0]     o_den,
    output tun_pkg::t_dv_side                 o_side
);

    logic                          r_valid;
    logic [DW-1:0]                 r_rem [3];
    logic [DW-1:0]                 n_rem [3];
    logic [QW-1:0]                 r_q   [3];
    logic [QW-1:0]                 n_q   [3];
    logic [DW-1:0]                 dsh;
    logic [tun_pkg::ROOT_BITS-1:0] r_den;
    tun_pkg::t_dv_side             r_side;

    always_comb begin
        dsh = DW'(i_den) << BIT_J;
        for (int k = 0; k < 3; k++) begin
            n_q[k] = i_q[k];
            if (i_rem[k] >= dsh) begin
                n_rem[k]    = i_rem[k] - dsh;
                n_q[k][BIT_J] = 1'b1;
            end else begin
                n_rem[k] = i_rem[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_den  <= i_den;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for triangle_unit_normal_core
// drives triangle requests with random gaps, predicts each unit normal in
// fixed point and checks every strobed result in order
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC      = tun_pkg::NORMAL_FRAC_BITS_DEF;
    localparam int N_RANDOM  = 1130;
    localparam int CYC_LIMIT = 400000;
    localparam int DRAIN     = 120;

    // one triangle request: coordinates ax ay az bx by bz cx cy cz
    typedef struct packed {
        logic [8:0][15:0] crd;
        logic             last;
    } t_tri;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
        logic        last;
    } t_norm;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] crd_q [9];
    logic        last_q;
    logic        o_valid;
    logic signed [15:0] o_nx, o_ny, o_nz;
    logic        o_degenerate, o_last_out;

    t_tri  tri_pending [$];
    t_norm norm_expected [$];
    int    n_sent;
    int    n_errors;
    int    cycles;
    int    pause_at;
    bit    stim_done;

    triangle_unit_normal_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_ax         (crd_q[0]),
        .i_ay         (crd_q[1]),
        .i_az         (crd_q[2]),
        .i_bx         (crd_q[3]),
        .i_by_coord   (crd_q[4]),
        .i_bz         (crd_q[5]),
        .i_cx         (crd_q[6]),
        .i_cy         (crd_q[7]),
        .i_cz         (crd_q[8]),
        .i_last_in    (last_q),
        .o_valid      (o_valid),
        .o_nx         (o_nx),
        .o_ny         (o_ny),
        .o_nz         (o_nz),
        .o_degenerate (o_degenerate),
        .o_last_out   (o_last_out)
    );

    // integer square root, floor
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // unit normal of one triangle
    function automatic t_norm unit_normal(input t_tri t);
        longint      p [9];
        longint      e1 [3];
        longint      e2 [3];
        longint      cr [3];
        logic [63:0] mag [3];
        logic [63:0] m [3];
        logic [63:0] sum, root, q;
        logic [15:0] comp [3];
        int          len, l, i;
        t_norm       res;
        for (i = 0; i < 9; i++) p[i] = longint'($signed(t.crd[8-i]));
        for (i = 0; i < 3; i++) begin
            e1[i] = p[3+i] - p[i];
            e2[i] = p[6+i] - p[i];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        len = 0;
        for (i = 0; i < 3; i++) begin
            mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
            l = 0;
            while (l < 64 && (mag[i] >> l) != 0) l++;
            if (l > len) len = l;
        end
        res.last = t.last;
        if (len == 0) begin
            res.nx = 0; res.ny = 0; res.nz = 0; res.degen = 1'b1;
            return res;
        end
        sum = 0;
        // common shift puts the largest leading one at bit 30
        for (i = 0; i < 3; i++) begin
            m[i] = (len > 31) ? (mag[i] >> (len - 31)) : (mag[i] << (31 - len));
            sum  = sum + m[i] * m[i];
        end
        root = floor_sqrt(sum);
        for (i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + (root >> 1)) / root;
            if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
            if (cr[i] < 0) q = ~q + 1;
            comp[i] = q[15:0];
        end
        res.nx = comp[0]; res.ny = comp[1]; res.nz = comp[2]; res.degen = 1'b0;
        return res;
    endfunction

    function automatic t_tri make_tri(input int ax, ay, az, bx, by, bz,
                                      cx, cy, cz, input bit lst);
        t_tri t;
        t.crd  = {ax[15:0], ay[15:0], az[15:0], bx[15:0], by[15:0], bz[15:0],
                  cx[15:0], cy[15:0], cz[15:0]};
        t.last = lst;
        return t;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // stimulus: directed triangles then random ones
    initial begin
        t_tri t;
        int   k, i, sel, lo, hi, dx, dy, dz;
        i_rst_n = 1'b0;
        stim_done = 0;
        pause_at  = $urandom_range(200, 900);

        // degenerate: all three vertices equal, and all zero
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        tri_pending.push_back(make_tri(5, -7, 9, 5, -7, 9, 5, -7, 9, 1'b1));
        // degenerate: collinear vertices
        tri_pending.push_back(make_tri(1, 2, 3, 3, 6, 9, 5, 10, 15, 1'b0));
        // axis aligned triangles, normals along plus z, minus z, plus x and plus y
        tri_pending.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b0));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0, 1'b0));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256, 1'b0));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0, 1'b1));
        // smallest possible edges
        tri_pending.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0));
        tri_pending.push_back(make_tri(-1, -1, -1, 0, -1, -1, -1, 0, -1, 1'b0));
        // full scale edges, two with a cross product that needs more than 64 bits of sum
        tri_pending.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                       -32768, 32767, -32768, 1'b0));
        tri_pending.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                                       -32768, 32767, 32767, 1'b1));
        tri_pending.push_back(make_tri(32767, 32767, 32767, -32768, 32767, -32768,
                                       32767, -32768, -32768, 1'b0));
        tri_pending.push_back(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                                       0, 0, 32767, 1'b0));
        // equal components, diagonal normal
        tri_pending.push_back(make_tri(256, 0, 0, 0, 256, 0, 0, 0, 256, 1'b0));
        tri_pending.push_back(make_tri(-256, 0, 0, 0, -256, 0, 0, 0, -256, 1'b1));
        // one huge component, the others tiny or zero
        tri_pending.push_back(make_tri(0, 0, 0, 32767, 0, 1, 0, 32767, 0, 1'b0));
        tri_pending.push_back(make_tri(0, 0, 0, -32768, 1, 0, 1, -32768, 0, 1'b0));

        for (k = 0; k < N_RANDOM; k++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                // full range coordinates
                for (i = 0; i < 9; i++) t.crd[i] = 16'($urandom);
            end else if (sel < 8) begin
                // small triangles around a random centre
                hi = 1 << $urandom_range(1, 12);
                lo = int'($urandom_range(0, 65535)) - 32768;
                for (i = 0; i < 9; i++)
                    t.crd[i] = 16'(lo / 2 + int'($urandom_range(0, hi)) - hi / 2);
            end else begin
                // collinear or coincident vertices
                for (i = 0; i < 3; i++) t.crd[8-i] = 16'(int'($urandom_range(0, 4000)) - 2000);
                dx = int'($urandom_range(0, 200)) - 100;
                dy = int'($urandom_range(0, 200)) - 100;
                dz = int'($urandom_range(0, 200)) - 100;
                sel = int'($urandom_range(0, 10)) - 5;
                t.crd[5] = t.crd[8] + 16'(dx);
                t.crd[4] = t.crd[7] + 16'(dy);
                t.crd[3] = t.crd[6] + 16'(dz);
                t.crd[2] = t.crd[8] + 16'(sel * dx);
                t.crd[1] = t.crd[7] + 16'(sel * dy);
                t.crd[0] = t.crd[6] + 16'(sel * dz);
            end
            t.last = $urandom_range(0, 7) == 0;
            tri_pending.push_back(t);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (tri_pending.size() == 0 && !start);
        wait (norm_expected.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        stim_done = 1;
        if (n_errors == 0)
            $display("triangle_unit_normal_core verification clean");
        else
            $display("triangle_unit_normal_core verification failed");
        $finish;
    end

    // driver: a request leaves at each edge with start high and busy low
    always @(posedge i_clk) begin
        t_tri t;
        int   i;
        bit   hold, gap;
        if (!i_rst_n) begin
            start  <= 1'b0;
            last_q <= 1'b0;
            for (i = 0; i < 9; i++) crd_q[i] <= '0;
        end else begin
            if (start && !busy) begin
                for (i = 0; i < 9; i++) t.crd[8-i] = crd_q[i];
                t.last = last_q;
                norm_expected.push_back(unit_normal(t));
                n_sent++;
            end
            if (!(start && busy)) begin
                // one pause that lets the pipeline drain completely
                hold = (n_sent == pause_at) && norm_expected.size() != 0;
                // long stretch with back to back requests
                gap  = !(n_sent >= 400 && n_sent < 650) && $urandom_range(0, 99) < 21;
                if (hold || gap || tri_pending.size() == 0) begin
                    start <= 1'b0;
                end else begin
                    t = tri_pending.pop_front();
                    for (i = 0; i < 9; i++) crd_q[i] <= t.crd[8-i];
                    last_q <= t.last;
                    start  <= 1'b1;
                end
            end
        end
    end

    // monitor: every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_norm e;
        if (i_rst_n && o_valid) begin
            if (norm_expected.size() == 0) begin
                $display("%0t: unexpected result nx=%0d ny=%0d nz=%0d", $time,
                         o_nx, o_ny, o_nz);
                n_errors++;
            end else begin
                e = norm_expected.pop_front();
                if (o_nx !== e.nx) begin
                    $display("%0t: nx expected %0d actual %0d", $time,
                             $signed(e.nx), o_nx);
                    n_errors++;
                end
                if (o_ny !== e.ny) begin
                    $display("%0t: ny expected %0d actual %0d", $time,
                             $signed(e.ny), o_ny);
                    n_errors++;
                end
                if (o_nz !== e.nz) begin
                    $display("%0t: nz expected %0d actual %0d", $time,
                             $signed(e.nz), o_nz);
                    n_errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $display("%0t: degenerate expected %0b actual %0b", $time,
                             e.degen, o_degenerate);
                    n_errors++;
                end
                if (o_last_out !== e.last) begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             e.last, o_last_out);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT && !stim_done) begin
            $display("triangle_unit_normal_core verification failed");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
design/tun_pkg.sv
design/tun_sqrt_cell.sv
design/tun_div_cell.sv
design/triangle_unit_normal_core.sv
sim/testbench.sv
